/* rtl/gcm_ghash_tag_engine_defines.svh */
// Assertion macros used by the GCM tag engine port checker gcm_chk.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef GCM_GHASH_TAG_ENGINE_DEFINES_SVH
`define GCM_GHASH_TAG_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gcm_pkg.sv */
// Shared types and constants for the GCM GHASH tag engine.
// No dependencies; every other source file of the block but the defines header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int COUNT_W     = 61;
   localparam int NBYTES_W    = 5;
   localparam int BLOCK_BYTES = 16;
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [1:0] {
      MODE_AAD    = 2'd0,
      MODE_TEXT   = 2'd1,
      MODE_TAG    = 2'd2,
      MODE_VERIFY = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_HI  = 2'd0,
      CSR_KEY_LO  = 2'd1,
      CSR_MASK_HI = 2'd2,
      CSR_MASK_LO = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/gcm_channels.sv */
// Handshake channel interfaces of the GCM tag engine: input words, tag words
// and register writes. Depends on gcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gcm_req_if import gcm_pkg::*; ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [HALF_W-1:0]   block_hi;
   logic [HALF_W-1:0]   block_lo;
   logic [NBYTES_W-1:0] valid_bytes;

   modport source (output valid, mode, block_hi, block_lo, valid_bytes, input ready);
   modport sink   (input valid, mode, block_hi, block_lo, valid_bytes, output ready);
endinterface

interface gcm_rsp_if import gcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] tag_hi;
   logic [HALF_W-1:0] tag_lo;
   logic              tag_match;

   modport source (output valid, tag_hi, tag_lo, tag_match, input ready);
   modport sink   (input valid, tag_hi, tag_lo, tag_match, output ready);
endinterface

interface gcm_csr_if import gcm_pkg::*; ();
   logic              valid;
   logic              ready;
   csr_index_type     reg_index;
   logic [HALF_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

/* rtl/gcm_gf_mult.sv */
// Combinational GF(2^128) multiplier in GCM bit order (bit 127 is x^0).
// Depends on gcm_pkg for the block width.
`timescale 1ns / 1ps
`default_nettype none

module gcm_gf_mult import gcm_pkg::*; (
   input  logic [BLOCK_W-1:0] op_a,
   input  logic [BLOCK_W-1:0] op_b,
   output logic [BLOCK_W-1:0] product
);

   function automatic logic [BLOCK_W-1:0] bit_reverse(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int k = 0; k < BLOCK_W; k++) begin
         r[k] = x[BLOCK_W-1-k];
      end
      return r;
   endfunction

   logic [BLOCK_W-1:0]     a_poly;
   logic [BLOCK_W-1:0]     b_poly;
   logic [2*BLOCK_W-2:0]   clmul;
   logic [BLOCK_W-2:0]     upper;
   logic [BLOCK_W+5:0]     fold1;
   logic [5:0]             spill;
   logic [BLOCK_W-1:0]     reduced;

   // Carry-less product of the two polynomials, then reduction modulo
   // x^128 + x^7 + x^2 + x + 1 in two folds.
   always_comb begin
      a_poly = bit_reverse(op_a);
      b_poly = bit_reverse(op_b);
      clmul  = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (b_poly[i]) begin
            clmul = clmul ^ ((2*BLOCK_W-1)'(a_poly) << i);
         end
      end
      upper   = clmul[2*BLOCK_W-2:BLOCK_W];
      fold1   = (BLOCK_W+6)'(clmul[BLOCK_W-1:0])
              ^ (BLOCK_W+6)'(upper)
              ^ ((BLOCK_W+6)'(upper) << 1)
              ^ ((BLOCK_W+6)'(upper) << 2)
              ^ ((BLOCK_W+6)'(upper) << 7);
      spill   = fold1[BLOCK_W+5:BLOCK_W];
      reduced = fold1[BLOCK_W-1:0]
              ^ BLOCK_W'(spill)
              ^ (BLOCK_W'(spill) << 1)
              ^ (BLOCK_W'(spill) << 2)
              ^ (BLOCK_W'(spill) << 7);
      product = bit_reverse(reduced);
   end

endmodule

`default_nettype wire

/* rtl/gcm_ghash_tag_engine.sv */
// GCM authentication engine: GHASH accumulation and tag finish.
// Depends on gcm_pkg, the channel interfaces and gcm_gf_mult.
//
// Usage:
//   req_ch carries one word per handshake: a 128-bit block of associated
//   data (mode AAD) or ciphertext (mode TEXT) with its count of leading valid
//   bytes, or a finish word (mode TAG or VERIFY). A finish word folds in the
//   bit-length block, produces the tag on rsp_ch and clears the hash state.
//   In VERIFY mode the block fields hold the received tag and tag_match
//   reports equality. Data words produce no response word.
//   csr_ch writes the hash subkey H and the mask E(K,J0); it is always ready
//   and must only be used while no word is in flight.
// Timing:
//   Every word is registered at the input and processed by one full 128x128
//   GF multiply, so one word is accepted per cycle unless a finish word waits
//   in the input register on an undrained tag word. A finish word's tag passes
//   the input register and then the output register before it is presented
//   on rsp_ch. The GF multiply feeding the accumulator is the critical path.
// Reset and stalls:
//   Reset clears the configuration registers, the accumulator, both byte
//   counters and all valid flags. While a tag word waits on rsp_ch, data
//   words keep flowing; only a second finish word waits in the input
//   register, and req_ch.ready drops until the output register is drained.
`timescale 1ns / 1ps
`default_nettype none

module gcm_ghash_tag_engine import gcm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   gcm_req_if.sink    req_ch,
   gcm_rsp_if.source  rsp_ch,
   gcm_csr_if.sink    csr_ch
);

   // Configuration registers.
   logic [HALF_W-1:0] key_hi_ff, key_hi_in;
   logic [HALF_W-1:0] key_lo_ff, key_lo_in;
   logic [HALF_W-1:0] mask_hi_ff, mask_hi_in;
   logic [HALF_W-1:0] mask_lo_ff, mask_lo_in;

   // Input register stage.
   logic                in_valid_ff, in_valid_in;
   mode_type            in_mode_ff;
   logic [HALF_W-1:0]   in_hi_ff;
   logic [HALF_W-1:0]   in_lo_ff;
   logic [NBYTES_W-1:0] in_nbytes_ff;

   // Hash state.
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] aad_cnt_ff, aad_cnt_in;
   logic [COUNT_W-1:0] txt_cnt_ff, txt_cnt_in;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [HALF_W-1:0] tag_hi_ff, tag_hi_in;
   logic [HALF_W-1:0] tag_lo_ff, tag_lo_in;
   logic              match_ff, match_in;

   logic                req_fire;
   logic                csr_fire;
   logic                is_finish;
   logic                advance;
   logic                load_out;
   logic [NBYTES_W-1:0] nbytes_sat;
   logic [BLOCK_W-1:0]  byte_mask;
   logic [BLOCK_W-1:0]  bit_lengths;
   logic [BLOCK_W-1:0]  mult_in;
   logic [BLOCK_W-1:0]  mult_out;
   logic [BLOCK_W-1:0]  tag_value;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // A data word never waits on the output side; a finish word needs the
   // output register empty or draining in this cycle.
   always_comb begin
      case (in_mode_ff) inside
         MODE_TAG, MODE_VERIFY: is_finish = 1'b1;
         default:               is_finish = 1'b0;
      endcase
   end

   assign advance      = in_valid_ff && (!is_finish || !out_valid_ff || rsp_ch.ready);
   assign load_out     = advance && is_finish;
   assign req_ch.ready = !in_valid_ff || advance;

   // Register writes.
   always_comb begin
      key_hi_in  = key_hi_ff;
      key_lo_in  = key_lo_ff;
      mask_hi_in = mask_hi_ff;
      mask_lo_in = mask_lo_ff;
      if (csr_fire) begin
         unique case (csr_ch.reg_index)
            CSR_KEY_HI:  key_hi_in  = csr_ch.wr_data;
            CSR_KEY_LO:  key_lo_in  = csr_ch.wr_data;
            CSR_MASK_HI: mask_hi_in = csr_ch.wr_data;
            CSR_MASK_LO: mask_lo_in = csr_ch.wr_data;
            default:     key_hi_in  = key_hi_ff;
         endcase
      end
   end

   // Zero padding of short blocks: byte 0 sits in the top bits of the block.
   always_comb begin
      nbytes_sat = (in_nbytes_ff > NBYTES_W'(BLOCK_BYTES))
                 ? NBYTES_W'(BLOCK_BYTES) : in_nbytes_ff;
      byte_mask = '0;
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         byte_mask[BLOCK_W-1-8*b -: 8] = (NBYTES_W'(b) < nbytes_sat) ? 8'hFF : 8'h00;
      end
   end

   // Length block: bit counts of associated data and ciphertext.
   assign bit_lengths = {aad_cnt_ff, 3'b000, txt_cnt_ff, 3'b000};

   assign mult_in = acc_ff ^ (is_finish ? bit_lengths : ({in_hi_ff, in_lo_ff} & byte_mask));

   gcm_gf_mult u_mult (
      .op_a    (mult_in),
      .op_b    ({key_hi_ff, key_lo_ff}),
      .product (mult_out)
   );

   assign tag_value = mult_out ^ {mask_hi_ff, mask_lo_ff};

   // Next state of the hash and the output register.
   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      acc_in       = acc_ff;
      aad_cnt_in   = aad_cnt_ff;
      txt_cnt_in   = txt_cnt_ff;
      out_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      tag_hi_in    = tag_hi_ff;
      tag_lo_in    = tag_lo_ff;
      match_in     = match_ff;
      if (advance) begin
         if (is_finish) begin
            acc_in     = '0;
            aad_cnt_in = '0;
            txt_cnt_in = '0;
            tag_hi_in  = tag_value[BLOCK_W-1:HALF_W];
            tag_lo_in  = tag_value[HALF_W-1:0];
            match_in   = (in_mode_ff == MODE_VERIFY) && (tag_value == {in_hi_ff, in_lo_ff});
         end else if (nbytes_sat != '0) begin
            // An empty data block leaves the state untouched.
            acc_in = mult_out;
            if (in_mode_ff == MODE_AAD) begin
               aad_cnt_in = aad_cnt_ff + COUNT_W'(nbytes_sat);
            end else begin
               txt_cnt_in = txt_cnt_ff + COUNT_W'(nbytes_sat);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         mask_hi_ff   <= '0;
         mask_lo_ff   <= '0;
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         aad_cnt_ff   <= '0;
         txt_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         mask_hi_ff   <= mask_hi_in;
         mask_lo_ff   <= mask_lo_in;
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         aad_cnt_ff   <= aad_cnt_in;
         txt_cnt_ff   <= txt_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff   <= req_ch.mode;
         in_hi_ff     <= req_ch.block_hi;
         in_lo_ff     <= req_ch.block_lo;
         in_nbytes_ff <= req_ch.valid_bytes;
      end
      tag_hi_ff <= tag_hi_in;
      tag_lo_ff <= tag_lo_in;
      match_ff  <= match_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.tag_hi    = tag_hi_ff;
   assign rsp_ch.tag_lo    = tag_lo_ff;
   assign rsp_ch.tag_match = match_ff;

endmodule

`default_nettype wire

/* rtl/gcm_chk.sv */
// Port-level checker for the GCM tag engine, attached by the bind below.
// Depends on gcm_pkg and gcm_ghash_tag_engine_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gcm_ghash_tag_engine_defines.svh"

module gcm_chk import gcm_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [1:0]        req_mode,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [HALF_W-1:0] rsp_tag_hi,
   input wire logic [HALF_W-1:0] rsp_tag_lo,
   input wire logic              rsp_tag_match
);

   // A tag word that is not taken holds its value.
   `GCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tag_hi) && $stable(rsp_tag_lo) && $stable(rsp_tag_match), "tag word changed while stalled")

   // Nothing is presented right after reset.
   `GCM_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_valid, "tag word valid after reset")

   // The input side only stalls behind an undrained tag word.
   `GCM_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready, "input stalled without output backpressure")

   // A new tag word follows a finish word that was taken and passed through the input and output registers.
   `GCM_ASSERT_NOW(a_tag_source, $rose(rsp_valid), $past(req_valid && req_ready && (req_mode == MODE_TAG || req_mode == MODE_VERIFY), 2), "tag word without a finish word")

endmodule

bind gcm_ghash_tag_engine gcm_chk u_gcm_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_mode      (req_ch.mode),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_tag_hi    (rsp_ch.tag_hi),
   .rsp_tag_lo    (rsp_ch.tag_lo),
   .rsp_tag_match (rsp_ch.tag_match)
);

`default_nettype wire

/* tb/sv/gcm_ghash_tag_checker.sv */
// Self-checking monitor for the GCM tag engine: follows register writes and input
// words, keeps its own GHASH state, and compares every tag word against it.
// Depends on gcm_pkg and the channel interfaces in gcm_channels.sv.
`timescale 1ns / 1ps

module gcm_ghash_tag_checker import gcm_pkg::*; (
   input  logic clock,
   input  logic reset,
   gcm_req_if   req_ch,
   gcm_rsp_if   rsp_ch,
   gcm_csr_if   csr_ch,
   output int   mismatch_count,
   output int   tags_outstanding
);

   typedef struct {
      logic [HALF_W-1:0] tag_hi;
      logic [HALF_W-1:0] tag_lo;
      logic              tag_match;
   } tag_word_type;

   logic [BLOCK_W-1:0] hash_key;
   logic [BLOCK_W-1:0] tag_mask;
   logic [BLOCK_W-1:0] ghash_acc;
   logic [COUNT_W-1:0] aad_bytes;
   logic [COUNT_W-1:0] text_bytes;
   tag_word_type       expected_tags[$];
   int                 errors = 0;

   // Multiply x by h in GF(2^128) with the reflected bit order that GCM uses.
   function automatic logic [BLOCK_W-1:0] gf128_times_h(input logic [BLOCK_W-1:0] x,
                                                        input logic [BLOCK_W-1:0] h);
      logic [BLOCK_W-1:0] z;
      logic [BLOCK_W-1:0] v;
      logic               carry;
      z = '0;
      v = h;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (x[BLOCK_W-1-i]) z ^= v;
         carry = v[0];
         v = v >> 1;
         if (carry) v[BLOCK_W-1 -: 8] ^= 8'hE1;
      end
      return z;
   endfunction

   always @(posedge clock) begin : watch
      tag_word_type       want;
      int                 nbytes;
      logic [BLOCK_W-1:0] keep;
      logic [BLOCK_W-1:0] tag;
      if (reset) begin
         hash_key   = '0;
         tag_mask   = '0;
         ghash_acc  = '0;
         aad_bytes  = '0;
         text_bytes = '0;
         expected_tags.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               CSR_KEY_HI:  hash_key[BLOCK_W-1:HALF_W] = csr_ch.wr_data;
               CSR_KEY_LO:  hash_key[HALF_W-1:0]       = csr_ch.wr_data;
               CSR_MASK_HI: tag_mask[BLOCK_W-1:HALF_W] = csr_ch.wr_data;
               CSR_MASK_LO: tag_mask[HALF_W-1:0]       = csr_ch.wr_data;
               default: ;
            endcase
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tags.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected tag word hi %h lo %h match %b", $realtime,
                           rsp_ch.tag_hi, rsp_ch.tag_lo, rsp_ch.tag_match);
            end else begin
               want = expected_tags.pop_front();
               if (rsp_ch.tag_hi !== want.tag_hi || rsp_ch.tag_lo !== want.tag_lo ||
                   rsp_ch.tag_match !== want.tag_match) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: tag expected %h_%h match %b, got %h_%h match %b",
                              $realtime, want.tag_hi, want.tag_lo, want.tag_match,
                              rsp_ch.tag_hi, rsp_ch.tag_lo, rsp_ch.tag_match);
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            nbytes = int'(req_ch.valid_bytes);
            if (req_ch.mode == MODE_AAD || req_ch.mode == MODE_TEXT) begin
               // An empty block is dropped; oversized counts behave as a full block.
               if (nbytes != 0) begin
                  if (nbytes > BLOCK_BYTES) nbytes = BLOCK_BYTES;
                  keep = {BLOCK_W{1'b1}} << (BLOCK_W - 8 * nbytes);
                  ghash_acc = gf128_times_h(ghash_acc ^
                                            ({req_ch.block_hi, req_ch.block_lo} & keep),
                                            hash_key);
                  if (req_ch.mode == MODE_AAD) aad_bytes = aad_bytes + COUNT_W'(nbytes);
                  else                         text_bytes = text_bytes + COUNT_W'(nbytes);
               end
            end else begin
               // Fold in the bit lengths, mask, and start a fresh message.
               ghash_acc = gf128_times_h(ghash_acc ^ {aad_bytes, 3'b000, text_bytes, 3'b000},
                                         hash_key);
               tag = ghash_acc ^ tag_mask;
               want.tag_hi    = tag[BLOCK_W-1:HALF_W];
               want.tag_lo    = tag[HALF_W-1:0];
               want.tag_match = (req_ch.mode == MODE_VERIFY) &&
                                (tag == {req_ch.block_hi, req_ch.block_lo});
               expected_tags.push_back(want);
               ghash_acc  = '0;
               aad_bytes  = '0;
               text_bytes = '0;
            end
         end
      end
      tags_outstanding <= expected_tags.size();
      mismatch_count   <= errors;
   end

endmodule

/* tb/sv/gcm_ghash_tag_engine_tb.sv */
// Top level of the GCM tag engine testbench: clock, reset, stimulus and verdict.
// Depends on gcm_pkg, the channel interfaces, the engine and gcm_ghash_tag_checker.
`timescale 1ns / 1ps

module gcm_ghash_tag_engine_tb;
   import gcm_pkg::*;

   // One input word as the sender sees it.
   typedef struct {
      mode_type              mode;
      logic [HALF_W-1:0]     hi;
      logic [HALF_W-1:0]     lo;
      logic [NBYTES_W-1:0]   nbytes;
   } req_word_type;

   // The multiplicative identity of GF(2^128) in the reflected bit order.
   localparam logic [BLOCK_W-1:0] GF_ONE = {1'b1, {(BLOCK_W-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcm_req_if req_ch ();
   gcm_rsp_if rsp_ch ();
   gcm_csr_if csr_ch ();

   int                 mismatches;
   int                 tags_pending;
   int                 counted_words = 0;
   int unsigned        rsp_stall = 0;
   logic               steady_sender = 1'b0;
   logic               steady_receiver = 1'b0;
   logic [BLOCK_W-1:0] last_tag = '0;
   req_word_type       message[$];

   gcm_ghash_tag_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   gcm_ghash_tag_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_ch           (csr_ch),
      .mismatch_count   (mismatches),
      .tags_outstanding (tags_pending)
   );

   always #1 clock = ~clock;

   // Tag receiver. After each accepted tag word it may hold ready low for a random
   // stall, unless the current message runs with a steady receiver. The last tag
   // is kept so that a message can be replayed as a verify with a matching tag.
   always @(posedge clock) begin : tag_receiver
      int unsigned draw;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         last_tag <= {rsp_ch.tag_hi, rsp_ch.tag_lo};
         draw = steady_receiver ? 0 : $urandom_range(0, 5);
         rsp_stall    <= draw;
         rsp_ch.ready <= (draw == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic logic [BLOCK_W-1:0] rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic req_word_type make_word(input mode_type mode,
                                              input logic [BLOCK_W-1:0] data,
                                              input logic [NBYTES_W-1:0] nbytes);
      req_word_type w;
      w.mode   = mode;
      w.hi     = data[BLOCK_W-1:HALF_W];
      w.lo     = data[HALF_W-1:0];
      w.nbytes = nbytes;
      return w;
   endfunction

   // Present one word after a random gap and hold it until accepted. Valid stays
   // high when the next word follows without a gap.
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= w.mode;
      req_ch.block_hi    <= w.hi;
      req_ch.block_lo    <= w.lo;
      req_ch.valid_bytes <= w.nbytes;
      do @(posedge clock); while (!req_ch.ready);
      // Empty data words are dropped by the engine and are not counted.
      if (w.mode == MODE_TAG || w.mode == MODE_VERIFY || w.nbytes != 0)
         counted_words++;
   endtask

   // Stop sending, wait until every tag word has come back, then give the engine
   // time to finish any data word still in its pipeline.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tags_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [HALF_W-1:0] data);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data   <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Write H and E(K,J0); called only while the engine is idle.
   task automatic load_keys(input logic [BLOCK_W-1:0] key, input logic [BLOCK_W-1:0] mask);
      put_reg(CSR_KEY_HI, key[BLOCK_W-1:HALF_W]);
      put_reg(CSR_KEY_LO, key[HALF_W-1:0]);
      put_reg(CSR_MASK_HI, mask[BLOCK_W-1:HALF_W]);
      put_reg(CSR_MASK_LO, mask[HALF_W-1:0]);
      csr_ch.valid <= 1'b0;
   endtask

   // Send the data words of the current message and close it. In a replay the
   // message is first closed with a plain tag request; once that tag is back, the
   // same data is sent again and closed with a verify carrying the tag, so that
   // the comparison can succeed. Now and then one bit of the tag is flipped.
   task automatic run_message(input bit replay, input mode_type finish_mode,
                              input logic [BLOCK_W-1:0] rx_tag);
      logic [BLOCK_W-1:0] seen;
      foreach (message[i]) send_word(message[i]);
      if (!replay) begin
         send_word(make_word(finish_mode, rx_tag, NBYTES_W'($urandom_range(0, 31))));
      end else begin
         send_word(make_word(MODE_TAG, rand_block(), NBYTES_W'($urandom_range(0, 31))));
         drain();
         seen = last_tag;
         if ($urandom_range(0, 3) == 0) seen[$urandom_range(0, BLOCK_W-1)] ^= 1'b1;
         foreach (message[i]) send_word(message[i]);
         send_word(make_word(MODE_VERIFY, seen, NBYTES_W'($urandom_range(0, 31))));
      end
   endtask

   // A random message: a few associated data blocks, then ciphertext blocks, with
   // mostly full blocks. Some messages are scrambled with arbitrary modes, which
   // can also put a finish in the middle.
   task automatic build_random_message();
      int unsigned  n_aad;
      int unsigned  n_text;
      int unsigned  pick;
      bit           scrambled;
      req_word_type w;
      message.delete();
      n_aad     = $urandom_range(0, 3);
      n_text    = $urandom_range(0, 4);
      scrambled = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n_aad + n_text; i++) begin
         if (scrambled)      w.mode = mode_type'($urandom_range(0, 3));
         else if (i < n_aad) w.mode = MODE_AAD;
         else                w.mode = MODE_TEXT;
         pick = $urandom_range(0, 9);
         if (pick <= 5)      w.nbytes = NBYTES_W'(BLOCK_BYTES);
         else if (pick <= 7) w.nbytes = NBYTES_W'($urandom_range(1, BLOCK_BYTES - 1));
         else if (pick == 8) w.nbytes = NBYTES_W'($urandom_range(BLOCK_BYTES + 1, 31));
         else                w.nbytes = '0;
         w.hi = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
         w.lo = ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom};
         message.push_back(w);
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_AAD;
      req_ch.block_hi    = '0;
      req_ch.block_lo    = '0;
      req_ch.valid_bytes = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.reg_index   = CSR_KEY_HI;
      csr_ch.wr_data     = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Finishes with no data in front give GHASH of the zero
      // length block; a verify on an empty message with a random tag mismatches.
      load_keys(rand_block(), rand_block());
      message.delete();
      run_message(1'b0, MODE_TAG, '1);
      run_message(1'b0, MODE_VERIFY, rand_block());

      // One message through all byte counts of interest: full, single byte, empty
      // (ignored), oversized counts (treated as full) and both sides of the
      // 64-bit boundary. It is replayed so that the verify can match.
      message.push_back(make_word(MODE_AAD, '1, NBYTES_W'(16)));
      message.push_back(make_word(MODE_AAD, '1, NBYTES_W'(1)));
      message.push_back(make_word(MODE_AAD, rand_block(), NBYTES_W'(0)));
      message.push_back(make_word(MODE_AAD, rand_block(), NBYTES_W'(31)));
      message.push_back(make_word(MODE_TEXT, rand_block(), NBYTES_W'(8)));
      message.push_back(make_word(MODE_TEXT, rand_block(), NBYTES_W'(9)));
      message.push_back(make_word(MODE_TEXT, '1, NBYTES_W'(15)));
      message.push_back(make_word(MODE_TEXT, '0, NBYTES_W'(17)));
      run_message(1'b1, MODE_VERIFY, '0);

      // Random part in several key settings: random, all ones, all zeros and the
      // identity element as H. Each setting starts from an idle engine.
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0:       load_keys(rand_block(), rand_block());
            1:       load_keys('1, '1);
            2:       load_keys('0, '0);
            3:       load_keys(GF_ONE, rand_block());
            default: load_keys(rand_block(), rand_block());
         endcase
         while (counted_words < 25 + 100 * (phase + 1)) begin
            steady_sender   = ($urandom_range(0, 3) == 0);
            steady_receiver = ($urandom_range(0, 3) == 0);
            build_random_message();
            run_message($urandom_range(0, 3) == 0,
                        ($urandom_range(0, 1) == 0) ? MODE_TAG : MODE_VERIFY,
                        rand_block());
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && tags_pending == 0)
         $display("gcm_ghash_tag_engine_tb: PASS");
      else
         $display("gcm_ghash_tag_engine_tb: FAIL");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #400000;
      $display("gcm_ghash_tag_engine_tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/gcm_pkg.sv
rtl/gcm_channels.sv
rtl/gcm_gf_mult.sv
rtl/gcm_ghash_tag_engine.sv
rtl/gcm_chk.sv
tb/sv/gcm_ghash_tag_checker.sv
tb/sv/gcm_ghash_tag_engine_tb.sv
